// ===== rtl/tml_pkg.sv =====
package tml_pkg;

    // Fixed field widths
    localparam int WEIGHT_WIDTH    = 16;
    localparam int WEIGHT_FRAC     = 15;
    localparam int LOSS_WIDTH      = 47;
    localparam int MARGIN_WIDTH    = 32;
    localparam int BSIZE_WIDTH     = 11;
    localparam int HINGE_WIDTH     = 64;
    localparam int HALF_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int M_TDATA_WIDTH   = ((2 * LOSS_WIDTH + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MARGIN     = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BATCH_SIZE = 1'b1;

    // Register reset values
    localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = 32'd16777216;
    localparam logic [BSIZE_WIDTH-1:0]  BSIZE_RESET  = 11'd1;

    localparam logic [LOSS_WIDTH-1:0] LOSS_MAX = {LOSS_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HINGE,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_LOSS,
        ST_BATCH,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/tml_front.sv =====
module tml_front #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_take,
    input  logic [DATA_WIDTH-1:0]                 anchor_value,
    input  logic [DATA_WIDTH-1:0]                 positive_value,
    input  logic [DATA_WIDTH-1:0]                 negative_value,
    input  logic [tml_pkg::WEIGHT_WIDTH-1:0]      sample_weight,
    input  logic                                  last_of_sample,
    input  logic                                  last_of_batch,
    output logic [1:0]                            inflight,
    output logic                                  push,
    output logic [ACC_WIDTH-1:0]                  push_dist_pos,
    output logic [ACC_WIDTH-1:0]                  push_dist_neg,
    output logic [tml_pkg::WEIGHT_WIDTH-1:0]      push_weight,
    output logic                                  push_last_batch
);

    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int SUM_W = ((ACC_WIDTH > SQ_W) ? ACC_WIDTH : SQ_W) + 1;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    logic [DATA_WIDTH:0]   diff_p, diff_n, neg_p, neg_n;
    logic [DATA_WIDTH-1:0] mag_p, mag_n;

    logic                              mag_valid_reg;
    logic [DATA_WIDTH-1:0]             mag_p_reg, mag_n_reg;
    logic [tml_pkg::WEIGHT_WIDTH-1:0]  mag_w_reg;
    logic                              mag_ls_reg, mag_lb_reg;

    logic                              sq_valid_reg;
    logic [SQ_W-1:0]                   sq_p_reg, sq_n_reg;
    logic [tml_pkg::WEIGHT_WIDTH-1:0]  sq_w_reg;
    logic                              sq_ls_reg, sq_lb_reg;

    logic [ACC_WIDTH-1:0] dist_pos_reg, dist_neg_reg;
    logic [ACC_WIDTH-1:0] dist_pos_next, dist_neg_next;
    logic [SUM_W-1:0]     sum_p, sum_n;
    logic [ACC_WIDTH-1:0] acc_p, acc_n;

    // Difference magnitudes always fit DATA_WIDTH bits
    assign diff_p = {anchor_value[DATA_WIDTH-1], anchor_value}
                  - {positive_value[DATA_WIDTH-1], positive_value};
    assign diff_n = {anchor_value[DATA_WIDTH-1], anchor_value}
                  - {negative_value[DATA_WIDTH-1], negative_value};
    assign neg_p  = -diff_p;
    assign neg_n  = -diff_n;
    assign mag_p  = diff_p[DATA_WIDTH] ? neg_p[DATA_WIDTH-1:0] : diff_p[DATA_WIDTH-1:0];
    assign mag_n  = diff_n[DATA_WIDTH] ? neg_n[DATA_WIDTH-1:0] : diff_n[DATA_WIDTH-1:0];

    // Saturating accumulate of the squares
    assign sum_p = SUM_W'(dist_pos_reg) + SUM_W'(sq_p_reg);
    assign sum_n = SUM_W'(dist_neg_reg) + SUM_W'(sq_n_reg);
    assign acc_p = (sum_p > SUM_W'(ACC_MAX)) ? ACC_MAX : sum_p[ACC_WIDTH-1:0];
    assign acc_n = (sum_n > SUM_W'(ACC_MAX)) ? ACC_MAX : sum_n[ACC_WIDTH-1:0];

    always_comb begin
        dist_pos_next = dist_pos_reg;
        dist_neg_next = dist_neg_reg;
        if (sq_valid_reg) begin
            if (sq_ls_reg) begin
                dist_pos_next = '0;
                dist_neg_next = '0;
            end else begin
                dist_pos_next = acc_p;
                dist_neg_next = acc_n;
            end
        end
    end

    assign push            = sq_valid_reg & sq_ls_reg;
    assign push_dist_pos   = acc_p;
    assign push_dist_neg   = acc_n;
    assign push_weight     = sq_w_reg;
    assign push_last_batch = sq_lb_reg;
    assign inflight        = {1'b0, mag_valid_reg} + {1'b0, sq_valid_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            dist_pos_reg  <= '0;
            dist_neg_reg  <= '0;
        end else begin
            mag_valid_reg <= in_take;
            sq_valid_reg  <= mag_valid_reg;
            dist_pos_reg  <= dist_pos_next;
            dist_neg_reg  <= dist_neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_p_reg  <= mag_p;
        mag_n_reg  <= mag_n;
        mag_w_reg  <= sample_weight;
        mag_ls_reg <= last_of_sample;
        mag_lb_reg <= last_of_batch;
        sq_p_reg   <= SQ_W'(mag_p_reg) * SQ_W'(mag_p_reg);
        sq_n_reg   <= SQ_W'(mag_n_reg) * SQ_W'(mag_n_reg);
        sq_w_reg   <= mag_w_reg;
        sq_ls_reg  <= mag_ls_reg;
        sq_lb_reg  <= mag_lb_reg;
    end

endmodule

// ===== rtl/tml_queue.sv =====
module tml_queue #(
    parameter int WIDTH = 113,
    parameter int DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// ===== rtl/tml_back.sv =====
module tml_back #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  logic [ACC_WIDTH-1:0]                q_dist_pos,
    input  logic [ACC_WIDTH-1:0]                q_dist_neg,
    input  logic [tml_pkg::WEIGHT_WIDTH-1:0]    q_weight,
    input  logic                                q_last_batch,
    output logic                                q_pop,
    input  logic [tml_pkg::MARGIN_WIDTH-1:0]    margin,
    input  logic [tml_pkg::BSIZE_WIDTH-1:0]     batch_size,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [tml_pkg::LOSS_WIDTH-1:0]      m_sample_loss,
    output logic                                m_hinge_active,
    output logic [tml_pkg::LOSS_WIDTH-1:0]      m_batch_loss,
    output logic                                m_batch_done
);

    localparam int POS_W    = ACC_WIDTH + 1;
    localparam int PROD_W   = tml_pkg::WEIGHT_WIDTH + tml_pkg::HALF_WIDTH;
    localparam int HI_SHIFT = tml_pkg::HALF_WIDTH - tml_pkg::WEIGHT_FRAC;
    localparam int TOP_KEEP = tml_pkg::LOSS_WIDTH - HI_SHIFT;
    localparam int R_W      = tml_pkg::LOSS_WIDTH + 1;
    localparam int BS_W     = ((ACC_WIDTH > tml_pkg::LOSS_WIDTH) ?
                               ACC_WIDTH : tml_pkg::LOSS_WIDTH) + 1;
    localparam int DV_W     = tml_pkg::BSIZE_WIDTH + 1;
    localparam int CNT_W    = $clog2(ACC_WIDTH);
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    tml_pkg::back_state_t state_reg, state_next;

    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic [ACC_WIDTH-1:0]               dan_reg, dan_next;
    logic [tml_pkg::WEIGHT_WIDTH-1:0]   w_reg, w_next;
    logic                               lb_reg, lb_next;
    logic [tml_pkg::HINGE_WIDTH-1:0]    h_reg, h_next;
    logic                               act_reg, act_next;
    logic [PROD_W-1:0]                  top_reg, top_next, lo_reg, lo_next;
    logic [tml_pkg::LOSS_WIDTH-1:0]     loss_reg, loss_next;
    logic [ACC_WIDTH-1:0]               bacc_reg, bacc_next;
    logic [DV_W-1:0]                    rem_reg, rem_next;
    logic [ACC_WIDTH-1:0]               quo_reg, quo_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;

    logic                               out_valid_reg, out_valid_next;
    logic [tml_pkg::LOSS_WIDTH-1:0]     out_loss_reg, out_loss_next;
    logic                               out_act_reg, out_act_next;
    logic [tml_pkg::LOSS_WIDTH-1:0]     out_bl_reg, out_bl_next;
    logic                               out_done_reg, out_done_next;

    logic [POS_W-1:0]                   pos_sum, hdiff;
    logic                               hinge_on;
    logic [tml_pkg::HALF_WIDTH-1:0]     mul_op;
    logic [PROD_W-1:0]                  prod;
    logic [R_W-1:0]                     r_sum;
    logic [BS_W-1:0]                    bsum;
    logic [ACC_WIDTH-1:0]               bacc_sat;
    logic [tml_pkg::BSIZE_WIDTH-1:0]    bs_eff;
    logic [DV_W:0]                      rs, rs_sub, divisor;
    logic                               ge;
    logic [tml_pkg::LOSS_WIDTH-1:0]     quo_sat;

    // Margin add; clamped to ACC_MAX only when ACC_WIDTH reaches the 64-bit hinge width
    assign pos_sum  = POS_W'(q_dist_pos) + POS_W'(margin);
    assign hinge_on = pos_reg > POS_W'(dan_reg);
    assign hdiff    = pos_reg - POS_W'(dan_reg);

    // One shared 16x32 multiplier, upper half first
    assign mul_op = (state_reg == tml_pkg::ST_MUL_HI) ?
                    h_reg[tml_pkg::HINGE_WIDTH-1:tml_pkg::HALF_WIDTH] :
                    h_reg[tml_pkg::HALF_WIDTH-1:0];
    assign prod   = PROD_W'(w_reg) * PROD_W'(mul_op);

    assign r_sum = R_W'({top_reg[TOP_KEEP-1:0], {HI_SHIFT{1'b0}}})
                 + R_W'(lo_reg[PROD_W-1:tml_pkg::WEIGHT_FRAC]);

    assign bsum     = BS_W'(bacc_reg) + BS_W'(loss_reg);
    assign bacc_sat = (bsum > BS_W'(ACC_MAX)) ? ACC_MAX : bsum[ACC_WIDTH-1:0];

    // Restoring divide by twice the batch size, one quotient bit a cycle
    assign bs_eff  = (batch_size == '0) ? tml_pkg::BSIZE_WIDTH'(1) : batch_size;
    assign divisor = {1'b0, bs_eff, 1'b0};
    assign rs      = {rem_reg, quo_reg[ACC_WIDTH-1]};
    assign ge      = rs >= divisor;
    assign rs_sub  = rs - divisor;
    assign quo_sat = ((quo_reg >> tml_pkg::LOSS_WIDTH) != '0) ?
                     tml_pkg::LOSS_MAX : tml_pkg::LOSS_WIDTH'(quo_reg);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        dan_next       = dan_reg;
        w_next         = w_reg;
        lb_next        = lb_reg;
        h_next         = h_reg;
        act_next       = act_reg;
        top_next       = top_reg;
        lo_next        = lo_reg;
        loss_next      = loss_reg;
        bacc_next      = bacc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_loss_next  = out_loss_reg;
        out_act_next   = out_act_reg;
        out_bl_next    = out_bl_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        q_pop          = 1'b0;

        case (state_reg)
            tml_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    pos_next   = ((ACC_WIDTH >= tml_pkg::HINGE_WIDTH) && pos_sum[ACC_WIDTH]) ?
                                 {1'b0, ACC_MAX} : pos_sum;
                    dan_next   = q_dist_neg;
                    w_next     = q_weight;
                    lb_next    = q_last_batch;
                    state_next = tml_pkg::ST_HINGE;
                end
            end
            tml_pkg::ST_HINGE: begin
                act_next   = hinge_on;
                h_next     = hinge_on ? tml_pkg::HINGE_WIDTH'(hdiff) : '0;
                state_next = tml_pkg::ST_MUL_HI;
            end
            tml_pkg::ST_MUL_HI: begin
                top_next   = prod;
                state_next = tml_pkg::ST_MUL_LO;
            end
            tml_pkg::ST_MUL_LO: begin
                lo_next    = prod;
                state_next = tml_pkg::ST_LOSS;
            end
            tml_pkg::ST_LOSS: begin
                loss_next  = ((top_reg[PROD_W-1:TOP_KEEP] != '0) ||
                              r_sum[tml_pkg::LOSS_WIDTH]) ?
                             tml_pkg::LOSS_MAX : r_sum[tml_pkg::LOSS_WIDTH-1:0];
                state_next = tml_pkg::ST_BATCH;
            end
            tml_pkg::ST_BATCH: begin
                if (lb_reg) begin
                    bacc_next  = '0;
                    quo_next   = bacc_sat;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(ACC_WIDTH - 1);
                    state_next = tml_pkg::ST_DIV;
                end else begin
                    bacc_next  = bacc_sat;
                    state_next = tml_pkg::ST_EMIT;
                end
            end
            tml_pkg::ST_DIV: begin
                rem_next = ge ? rs_sub[DV_W-1:0] : rs[DV_W-1:0];
                quo_next = {quo_reg[ACC_WIDTH-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = tml_pkg::ST_EMIT;
                end
            end
            tml_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_loss_next  = loss_reg;
                    out_act_next   = act_reg;
                    out_bl_next    = lb_reg ? quo_sat : '0;
                    out_done_next  = lb_reg;
                    state_next     = tml_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tml_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tml_pkg::ST_IDLE;
            bacc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bacc_reg      <= bacc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        dan_reg      <= dan_next;
        w_reg        <= w_next;
        lb_reg       <= lb_next;
        h_reg        <= h_next;
        act_reg      <= act_next;
        top_reg      <= top_next;
        lo_reg       <= lo_next;
        loss_reg     <= loss_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        out_loss_reg <= out_loss_next;
        out_act_reg  <= out_act_next;
        out_bl_reg   <= out_bl_next;
        out_done_reg <= out_done_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_sample_loss  = out_loss_reg;
    assign m_hinge_active = out_act_reg;
    assign m_batch_loss   = out_bl_reg;
    assign m_batch_done   = out_done_reg;

endmodule

// ===== rtl/triplet_margin_loss_core.sv =====
// Triplet margin loss over squared Euclidean distances, streamed per feature element.
//
// s_ channel: one item per feature element. s_tdata carries anchor, positive and
// negative (signed Q4.12) and the sample weight (Q1.15); s_tlast closes a triplet,
// s_tuser marks the last triplet of a batch (read only together with s_tlast).
// m_ channel: one item per triplet with the weighted hinge term and its active flag;
// m_tlast closes a batch and then m_tdata also carries the batch sum over twice the
// batch size. cfg_ writes margin (index 0) and batch_size (index 1); write only idle.
//
// The front end squares and accumulates one element per cycle (3-stage pipeline) and
// drops each finished triplet into a short queue. The back end handles one triplet at
// a time, stepping through hinge, multiply, loss, batch and emit states, plus the
// bit-serial divider when the triplet closes a batch. Short triplets are bounded by the
// back end; triplets of 7 or more elements stream at one element per cycle while the
// receiver keeps up and no batch end is in the divider.
// Reset clears all accumulators and the queue and loads margin 1.0 and batch size 1.
// When the receiver stalls, the result holds in the output register, the back end
// stops at its next result, the queue fills and s_tready then drops.
module triplet_margin_loss_core #(
    parameter int DATA_WIDTH  = 16,
    parameter int ACC_WIDTH   = 48,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // anchor, positive, negative (DATA_WIDTH each), sample_weight (16), zero pad
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((3*DATA_WIDTH+16+7)/8)*8-1:0]    s_tdata,
    input  logic                                    s_tlast,  // last_of_sample
    input  logic                                    s_tuser,  // last_of_batch
    // sample_loss (47), batch_loss (47), zero pad
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [tml_pkg::M_TDATA_WIDTH-1:0]       m_tdata,
    output logic                                    m_tlast,  // batch_done
    output logic                                    m_tuser,  // hinge_active
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tml_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [tml_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    localparam int ENTRY_W = 2 * ACC_WIDTH + tml_pkg::WEIGHT_WIDTH + 1;
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CR_W    = QC_W + 2;
    localparam int PAD_W   = tml_pkg::M_TDATA_WIDTH - 2 * tml_pkg::LOSS_WIDTH;

    logic [tml_pkg::MARGIN_WIDTH-1:0] margin_reg;
    logic [tml_pkg::BSIZE_WIDTH-1:0]  batch_size_reg;

    logic                              s_take;
    logic [1:0]                        inflight;
    logic                              push, pop, q_empty;
    logic [ACC_WIDTH-1:0]              push_dist_pos, push_dist_neg;
    logic [tml_pkg::WEIGHT_WIDTH-1:0]  push_weight;
    logic                              push_last_batch;
    logic [ENTRY_W-1:0]                push_entry, pop_entry;
    logic [QC_W-1:0]                   q_count;

    logic [tml_pkg::LOSS_WIDTH-1:0]    sample_loss, batch_loss;

    // Config registers; writes always land
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg     <= tml_pkg::MARGIN_RESET;
            batch_size_reg <= tml_pkg::BSIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tml_pkg::REG_MARGIN:     margin_reg     <= cfg_data;
                tml_pkg::REG_BATCH_SIZE: batch_size_reg <= cfg_data[tml_pkg::BSIZE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Credit check: every item in the front pipeline may need a queue slot
    assign s_tready = (CR_W'(q_count) + CR_W'(inflight)) < CR_W'(QUEUE_DEPTH);
    assign s_take   = s_tvalid & s_tready;

    tml_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_take         (s_take),
        .anchor_value    (s_tdata[DATA_WIDTH-1:0]),
        .positive_value  (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .negative_value  (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .sample_weight   (s_tdata[3*DATA_WIDTH+tml_pkg::WEIGHT_WIDTH-1:3*DATA_WIDTH]),
        .last_of_sample  (s_tlast),
        .last_of_batch   (s_tuser),
        .inflight        (inflight),
        .push            (push),
        .push_dist_pos   (push_dist_pos),
        .push_dist_neg   (push_dist_neg),
        .push_weight     (push_weight),
        .push_last_batch (push_last_batch)
    );

    assign push_entry = {push_last_batch, push_weight, push_dist_neg, push_dist_pos};

    tml_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .empty     (q_empty),
        .count     (q_count)
    );

    tml_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_dist_pos     (pop_entry[ACC_WIDTH-1:0]),
        .q_dist_neg     (pop_entry[2*ACC_WIDTH-1:ACC_WIDTH]),
        .q_weight       (pop_entry[ENTRY_W-2:2*ACC_WIDTH]),
        .q_last_batch   (pop_entry[ENTRY_W-1]),
        .q_pop          (pop),
        .margin         (margin_reg),
        .batch_size     (batch_size_reg),
        .m_ready        (m_tready),
        .m_valid        (m_tvalid),
        .m_sample_loss  (sample_loss),
        .m_hinge_active (m_tuser),
        .m_batch_loss   (batch_loss),
        .m_batch_done   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, batch_loss, sample_loss};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int ACC_W         = 48;
    localparam int S_TDATA_W     = ((3 * 16 + tml_pkg::WEIGHT_WIDTH + 7) / 8) * 8;
    localparam int LIMIT_CYCLES  = 2_000_000;
    // settling time for the back end, including the divider at a batch end
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 960;

    typedef logic [ACC_W-1:0]               acc_t;
    typedef logic [tml_pkg::LOSS_WIDTH-1:0] loss_t;

    localparam acc_t ACC_FULL = '1;

    typedef struct packed {
        loss_t sample_loss;
        logic  hinge_on;
        loss_t batch_loss;
        logic  batch_end;
    } triplet_result_t;

    localparam triplet_result_t NO_RESULT = '0;

    // ROW_RUN rows are checked against the predictor, ROW_TYPED rows against the
    // result typed into the row, ROW_CFG rows write a register once the block is idle
    typedef enum logic [1:0] {
        ROW_RUN,
        ROW_TYPED,
        ROW_CFG
    } row_kind_e;

    // reps repeats the element; the sample and batch flags go on the final copy only
    typedef struct packed {
        row_kind_e                           kind;
        shortint                             anc;
        shortint                             pos;
        shortint                             neg;
        logic [tml_pkg::WEIGHT_WIDTH-1:0]    weight;
        logic                                sample_end;
        logic                                batch_flag;
        int                                  reps;
        logic [tml_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [tml_pkg::CFG_DATA_WIDTH-1:0]  reg_val;
        triplet_result_t                     typed;
    } stim_row_t;

    localparam stim_row_t DIRECTED [19] = '{
        // zero distances right after reset: loss is the 1.0 margin, batch of one halves it
        '{ROW_TYPED, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, '{47'd16777216, 1'b1, 47'd8388608, 1'b1}},
        // zero weight keeps the hinge flag
        '{ROW_TYPED, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, '{47'd0, 1'b1, 47'd0, 1'b1}},
        // full-scale differences over two elements
        '{ROW_RUN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_RUN, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        // batch flag without the sample flag is ignored
        '{ROW_RUN, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_RUN, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        // negative far enough to switch the hinge off
        '{ROW_TYPED, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1'b1, 1'b0, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_CFG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_TYPED, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, '{47'd0, 1'b0, 47'd0, 1'b1}},
        '{ROW_CFG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
          tml_pkg::REG_MARGIN, 32'hFFFF_FFFF, NO_RESULT},
        // batch size zero divides as one
        '{ROW_CFG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
          tml_pkg::REG_BATCH_SIZE, 32'd0, NO_RESULT},
        '{ROW_RUN, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_CFG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
          tml_pkg::REG_BATCH_SIZE, 32'd1024, NO_RESULT},
        // long triplets: the hinge reaches the upper half of the weighting product
        // and the batch sum spans several large terms
        '{ROW_RUN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, 48,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_RUN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b0, 64,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        '{ROW_RUN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1, 40,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT},
        // negative distance grows past the full margin, the hinge goes off
        '{ROW_TYPED, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 1'b1, 40,
          tml_pkg::REG_MARGIN, 32'd0, '{47'd0, 1'b0, 47'd0, 1'b1}},
        '{ROW_CFG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1,
          tml_pkg::REG_BATCH_SIZE, 32'd2047, NO_RESULT},
        '{ROW_RUN, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b1, 1'b1, 1,
          tml_pkg::REG_MARGIN, 32'd0, NO_RESULT}
    };

    localparam shortint EDGE_VALS [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

    logic                                  aclk;
    logic                                  aresetn   = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [S_TDATA_W-1:0]                  s_tdata   = '0;
    logic                                  s_tlast   = 1'b0;
    logic                                  s_tuser   = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [tml_pkg::M_TDATA_WIDTH-1:0]     m_tdata;
    logic                                  m_tlast;
    logic                                  m_tuser;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [tml_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [tml_pkg::CFG_DATA_WIDTH-1:0]    cfg_data  = '0;

    triplet_margin_loss_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // anchor, positive, negative, sample_weight
        .s_tlast   (s_tlast),   // last_of_sample
        .s_tuser   (s_tuser),   // last_of_batch
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // sample_loss, batch_loss, zero pad
        .m_tlast   (m_tlast),   // batch_done
        .m_tuser   (m_tuser),   // hinge_active
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: its own copy of the registers and accumulators
    logic [tml_pkg::MARGIN_WIDTH-1:0] margin_q824    = tml_pkg::MARGIN_RESET;
    logic [tml_pkg::BSIZE_WIDTH-1:0]  bsize_reg      = tml_pkg::BSIZE_RESET;
    acc_t                             pos_dist_sum   = '0;
    acc_t                             neg_dist_sum   = '0;
    acc_t                             batch_term_sum = '0;

    triplet_result_t loss_queue [$];

    int tx_idle_pct = 38;
    int rx_idle_pct = 87;
    int errors      = 0;
    int cycle_count = 0;
    int n_elements  = 0;
    int n_triplets  = 0;
    int n_active    = 0;
    int n_batches   = 0;
    int n_writes    = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic acc_t sat_acc(acc_t acc, logic [63:0] inc);
        logic [64:0] total;
        total = 65'(acc) + 65'(inc);
        return (total > 65'(ACC_FULL)) ? ACC_FULL : total[ACC_W-1:0];
    endfunction

    function automatic logic [63:0] sq_diff(shortint x, shortint y);
        int d;
        d = int'(x) - int'(y);
        if (d < 0) d = -d;
        return 64'(d) * 64'(d);
    endfunction

    // Advance the predictor by one element; returns 1 when the element closes a triplet
    function automatic bit predict_element(input shortint a, input shortint p,
                                           input shortint n,
                                           input logic [tml_pkg::WEIGHT_WIDTH-1:0] w,
                                           input logic sample_end, input logic batch_flag,
                                           output triplet_result_t res);
        logic [63:0] reach;
        logic [63:0] hinge;
        logic [79:0] weighted;
        logic [11:0] divisor;
        acc_t        quot;
        res = NO_RESULT;
        pos_dist_sum = sat_acc(pos_dist_sum, sq_diff(a, p));
        neg_dist_sum = sat_acc(neg_dist_sum, sq_diff(a, n));
        if (!sample_end) return 1'b0;

        reach        = 64'(pos_dist_sum) + 64'(margin_q824);
        res.hinge_on = reach > 64'(neg_dist_sum);
        hinge        = res.hinge_on ? reach - 64'(neg_dist_sum) : 64'd0;
        weighted     = (80'(w) * 80'(hinge)) >> tml_pkg::WEIGHT_FRAC;
        res.sample_loss = (weighted > 80'(tml_pkg::LOSS_MAX)) ?
                          tml_pkg::LOSS_MAX : weighted[tml_pkg::LOSS_WIDTH-1:0];
        batch_term_sum  = sat_acc(batch_term_sum, 64'(res.sample_loss));
        res.batch_end   = batch_flag;
        if (batch_flag) begin
            divisor = (bsize_reg == '0) ? 12'd2 : {bsize_reg, 1'b0};
            quot    = batch_term_sum / acc_t'(divisor);
            res.batch_loss = (quot > acc_t'(tml_pkg::LOSS_MAX)) ?
                             tml_pkg::LOSS_MAX : quot[tml_pkg::LOSS_WIDTH-1:0];
            batch_term_sum = '0;
        end
        pos_dist_sum = '0;
        neg_dist_sum = '0;
        return 1'b1;
    endfunction

    // Offer one element, hold it until taken, then queue its result if it has one.
    // Called and left at a falling edge; tvalid stays high for a following item.
    task automatic drive_element(shortint a, shortint p, shortint n,
                                 logic [tml_pkg::WEIGHT_WIDTH-1:0] w, logic sample_end,
                                 logic batch_flag, bit use_typed,
                                 triplet_result_t typed_res);
        triplet_result_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, n, p, a};
        s_tlast  <= sample_end;
        s_tuser  <= batch_flag;
        do @(posedge aclk); while (!s_tready);
        if (predict_element(a, p, n, w, sample_end, batch_flag, res))
            loss_queue.push_back(use_typed ? typed_res : res);
        n_elements++;
        @(negedge aclk);
    endtask

    // Drop the input stream, let every expected result arrive and the back end
    // settle, then write one register
    task automatic write_register(logic [tml_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  logic [tml_pkg::CFG_DATA_WIDTH-1:0] val);
        s_tvalid <= 1'b0;
        while (loss_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == tml_pkg::REG_MARGIN)
            margin_q824 = val[tml_pkg::MARGIN_WIDTH-1:0];
        else
            bsize_reg = val[tml_pkg::BSIZE_WIDTH-1:0];
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall at random at the current rate
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker: compare each taken item with the oldest expectation
    always @(posedge aclk) begin
        triplet_result_t want;
        loss_t           got_loss;
        loss_t           got_batch;
        got_loss  = m_tdata[tml_pkg::LOSS_WIDTH-1:0];
        got_batch = m_tdata[2*tml_pkg::LOSS_WIDTH-1:tml_pkg::LOSS_WIDTH];
        if (aresetn && m_tvalid && m_tready) begin
            if (loss_queue.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected: sample_loss %0d",
                         $time, got_loss);
                $display("%0t: expected no item, actual batch_loss %0d",
                         $time, got_batch);
            end else begin
                want = loss_queue.pop_front();
                n_triplets++;
                if (want.hinge_on) n_active++;
                if (want.batch_end) n_batches++;
                if (got_loss !== want.sample_loss) begin
                    errors++;
                    $display("%0t: sample_loss expected %0d actual %0d",
                             $time, want.sample_loss, got_loss);
                end
                if (m_tuser !== want.hinge_on) begin
                    errors++;
                    $display("%0t: hinge_active expected %0b actual %0b",
                             $time, want.hinge_on, m_tuser);
                end
                if (got_batch !== want.batch_loss) begin
                    errors++;
                    $display("%0t: batch_loss expected %0d actual %0d",
                             $time, want.batch_loss, got_batch);
                end
                if (m_tlast !== want.batch_end) begin
                    errors++;
                    $display("%0t: batch_done expected %0b actual %0b",
                             $time, want.batch_end, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                     $time, cycle_count, loss_queue.size());
            $display("triplet_margin_loss_core test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [tml_pkg::CFG_DATA_WIDTH-1:0] m_val;
        logic [tml_pkg::BSIZE_WIDTH-1:0]    b_val;
        logic [tml_pkg::WEIGHT_WIDTH-1:0]   w;
        shortint                            a, p, n;
        int                                 sent, n_trip, len, mode;
        logic                               is_last, flag;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, under the first idling pattern
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                write_register(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                for (int k = 1; k < DIRECTED[i].reps; k++)
                    drive_element(DIRECTED[i].anc, DIRECTED[i].pos, DIRECTED[i].neg,
                                  DIRECTED[i].weight, 1'b0, 1'b0, 1'b0, NO_RESULT);
                drive_element(DIRECTED[i].anc, DIRECTED[i].pos, DIRECTED[i].neg,
                              DIRECTED[i].weight, DIRECTED[i].sample_end,
                              DIRECTED[i].batch_flag, DIRECTED[i].kind == ROW_TYPED,
                              DIRECTED[i].typed);
            end
        end

        // Random batches: three idling patterns, two register settings in each
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 87 : 0;
            rx_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 38 : 0;
            for (int part = 0; part < 2; part++) begin
                case ($urandom_range(4))
                    0:       m_val = '0;
                    1:       m_val = '1;
                    2:       m_val = tml_pkg::MARGIN_RESET;
                    3:       m_val = $urandom_range(32'h1000_0000);
                    default: m_val = $urandom();
                endcase
                case ($urandom_range(5))
                    0:       b_val = '0;
                    1:       b_val = 11'd1024;
                    2:       b_val = '1;
                    default: b_val = tml_pkg::BSIZE_WIDTH'($urandom_range(1, 8));
                endcase
                write_register(tml_pkg::REG_MARGIN, m_val);
                write_register(tml_pkg::REG_BATCH_SIZE, tml_pkg::CFG_DATA_WIDTH'(b_val));

                sent = 0;
                while (sent < RANDOM_ITEMS / 6) begin
                    // a well-formed batch has batch_size triplets; zero and large sizes get short ones
                    n_trip = (bsize_reg >= 1 && bsize_reg <= 8) ? int'(bsize_reg)
                                                                : $urandom_range(1, 6);
                    for (int t = 0; t < n_trip; t++) begin
                        len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 8);
                        mode = $urandom_range(3);
                        for (int e = 0; e < len; e++) begin
                            case (mode)
                                0: begin
                                    a = shortint'($urandom());
                                    p = shortint'($urandom());
                                    n = shortint'($urandom());
                                end
                                1: begin
                                    // close values keep the hinge mostly on
                                    a = shortint'($urandom_range(1023)) - 16'sd512;
                                    p = a + shortint'($urandom_range(63)) - 16'sd32;
                                    n = a + shortint'($urandom_range(1023)) - 16'sd512;
                                end
                                2: begin
                                    a = EDGE_VALS[$urandom_range(3)];
                                    p = EDGE_VALS[$urandom_range(3)];
                                    n = EDGE_VALS[$urandom_range(3)];
                                end
                                default: begin
                                    a = shortint'($urandom());
                                    p = a ^ shortint'($urandom_range(15));
                                    n = shortint'($urandom());
                                end
                            endcase
                            case ($urandom_range(9))
                                0:       w = '0;
                                1:       w = '1;
                                default: w = tml_pkg::WEIGHT_WIDTH'($urandom());
                            endcase
                            is_last = (e == len - 1);
                            // stray batch flags mid-triplet and early batch ends as noise
                            flag = is_last ? (t == n_trip - 1 || $urandom_range(24) == 0)
                                           : ($urandom_range(19) == 0);
                            drive_element(a, p, n, w, is_last, flag, 1'b0, NO_RESULT);
                            sent++;
                        end
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (loss_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d feature elements and %0d triplet results",
                 n_elements, n_triplets);
        $display("%0d with hinge on, %0d closing a batch, %0d register writes",
                 n_active, n_batches, n_writes);
        if (errors == 0)
            $display("triplet_margin_loss_core test passed");
        else
            $display("triplet_margin_loss_core test failed");
        $finish;
    end

endmodule
